// ----- hw/rtl/sha_pkg.sv -----
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hash.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned LenPos     = 56;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } core_ctl_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t start_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
// ---------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message beats and digest beats.
// ---------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha_core.sv -----
// ---------------------------------------------------------------------------
// sha_core
// Shared round unit: one SHA-256 round per cycle with a 16-word schedule
// window, then the chaining add. Words enter through a shift-in port.
// ---------------------------------------------------------------------------
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sha_pkg::word_t      load_word_i,
  input  sha_pkg::core_ctl_t  ctl_i,
  input  logic                reinit_i,
  input  logic [2:0]          rd_idx_i,
  output sha_pkg::word_t      rd_word_o,
  output logic                done_o
);
  import sha_pkg::*;

  word_t      w_q [16];
  word_t      v_q [8];
  word_t      h_q [8];
  logic [5:0] rnd_q;
  logic       run_q, add_q;
  word_t      t1, t2, s0, s1, wn, e, a;

  assign e  = v_q[4];
  assign a  = v_q[0];
  assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wn = w_q[0] + s0 + w_q[9] + s1;
  assign t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(rnd_q) + w_q[0];
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign rd_word_o = h_q[rd_idx_i];
  assign done_o    = add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      run_q <= 1'b0;
      add_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= start_h(3'(i));
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      add_q <= 1'b0;
      if (reinit_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= start_h(3'(i));
      end else if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        v_q[0] <= t1 + t2;
        v_q[1] <= v_q[0];
        v_q[2] <= v_q[1];
        v_q[3] <= v_q[2];
        v_q[4] <= v_q[3] + t1;
        v_q[5] <= v_q[4];
        v_q[6] <= v_q[5];
        v_q[7] <= v_q[6];
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
        if (rnd_q == 6'd63) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end
      if (add_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (load_i) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= load_word_i;
      end
    end
  end
endmodule

// ----- hw/rtl/sha256_stream_hash.sv -----
// ---------------------------------------------------------------------------
// sha256_stream_hash
// Streaming SHA-256 over a byte stream with an eight-word digest output.
// ---------------------------------------------------------------------------
// Channels: in_i carries one message beat (data_byte, byte_present,
// end_of_message); out_o carries eight digest beats, word_index 0..7,
// last_word on the eighth.
// Bytes pack into 32-bit words that shift into the schedule window; a byte
// that completes a block holds off further beats while the block runs 64
// rounds in the shared round unit and then the chaining add.
// An end-of-message beat pads one byte per cycle while no block is running,
// up to the length field, in one or two blocks, then offers eight digest
// beats, one per cycle while out_o.ready is high; a stall holds the current
// beat. in_i.ready is low from end of message till the last one is taken.
// Reset loads the initial hash values and clears the byte counters.
// ---------------------------------------------------------------------------
module sha256_stream_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q;
  logic [60:0] len_q;
  logic [23:0] acc_q;
  logic [2:0]  oidx_q;
  logic        fin_q;
  logic        wrap_q;
  logic [7:0]  pbyte;
  logic        put, load, done, reinit;
  core_ctl_t   ctl;
  word_t       rd_word;
  logic [63:0] bits;

  assign bits = {len_q, 3'b000};

  always_comb begin
    if (!fin_q) pbyte = 8'h80;
    else if (cnt_q >= 6'(LenPos) && !wrap_q) pbyte = bits[8*(63-cnt_q) +: 8] ;
    else pbyte = 8'h00;
  end

  // fin_q set means the 0x80 byte is already in
  logic [7:0] byte_v;
  always_comb begin
    byte_v = (state_q == ST_PAD) ? pbyte : in_i.data_byte;
    put = (state_q == ST_IDLE && in_i.valid && in_i.byte_present) ||
          (state_q == ST_PAD);
    load = put && (cnt_q[1:0] == 2'b11);
  end

  assign ctl.start = put && (cnt_q == 6'd63);
  assign reinit    = (state_q == ST_OUT) && out_o.ready && (oidx_q == 3'd7);

  sha_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .load_word_i({acc_q, byte_v}),
    .ctl_i      (ctl),
    .reinit_i   (reinit),
    .rd_idx_i   (oidx_q),
    .rd_word_o  (rd_word),
    .done_o     (done)
  );

  logic blk_run_q, eom_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_i.valid) begin
        if (ctl.start) state_d = ST_ROUND;
        else if (in_i.end_of_message) state_d = ST_PAD;
      end
      ST_ROUND: if (done) state_d = ST_ADD;
      ST_ADD: state_d = eom_q ? ST_PAD : ST_IDLE;
      ST_PAD: begin
        if (ctl.start) state_d = ST_ROUND;
        else if (fin_q && cnt_q == 6'd63) state_d = ST_ROUND;
      end
      ST_OUT: if (reinit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_ADD && eom_q && blk_run_q) state_d = ST_OUT;
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    out_o.valid = (state_q == ST_OUT);
    out_o.digest_word = rd_word;
    out_o.word_index = oidx_q;
    out_o.last_word = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      len_q <= '0;
      acc_q <= '0;
      oidx_q <= '0;
      fin_q <= 1'b0;
      wrap_q <= 1'b0;
      eom_q <= 1'b0;
      blk_run_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (put) begin
        cnt_q <= cnt_q + 6'd1;
        acc_q <= {acc_q[15:0], byte_v};
      end
      if (state_q == ST_IDLE && in_i.valid) begin
        if (in_i.byte_present) len_q <= len_q + 61'd1;
        eom_q <= in_i.end_of_message;
      end
      if (state_q == ST_PAD) begin
        fin_q <= 1'b1;
        if (!fin_q) begin
          wrap_q <= (cnt_q >= 6'(LenPos)) && (cnt_q != 6'd63);
        end else if (cnt_q == 6'd63) begin
          if (wrap_q) wrap_q <= 1'b0;
          else blk_run_q <= 1'b1;
        end
      end
      if (state_q == ST_OUT && out_o.ready) oidx_q <= oidx_q + 3'd1;
      if (reinit) begin
        len_q <= '0;
        fin_q <= 1'b0;
        wrap_q <= 1'b0;
        eom_q <= 1'b0;
        blk_run_q <= 1'b0;
        cnt_q <= '0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while digest pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(oidx_q)))
    else $error("digest beat dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.start |=> state_q == ST_ROUND)
    else $error("block start without rounds");
endmodule

// ----- tb/sha256_stream_hash_check.sv -----
// ---------------------------------------------------------------------------
// sha256_stream_hash_check
// Watches both channels of the stream hash. Every accepted message beat runs
// through a local SHA-256 predictor; every digest beat is compared with the
// oldest predicted word.
// ---------------------------------------------------------------------------
module sha256_stream_hash_check (
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if    msg_mon,
  sha_out_if   dig_mon,
  output int   errors_o,
  output int   pending_o,
  output int   digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  int unsigned  block_fill;
  logic [60:0]  byte_count;
  digest_beat_t digest_fifo [$];
  int           mismatches;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      sched[i] = sched[i-16] + sched[i-7]
               + (rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + sched[i];
      t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endtask

  task automatic finish_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    bit_len = {byte_count, 3'b000};
    absorb_byte(8'h80);
    while (block_fill != 56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      beat.word  = hash_state[i];
      beat.index = 3'(i);
      beat.last  = (i == 7);
      digest_fifo.push_back(beat);
    end
    for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
    block_fill = 0;
    byte_count = '0;
  endtask

  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
      block_fill = 0;
      byte_count = '0;
      digest_fifo.delete();
      pending_o  = 0;
      mismatches <= 0;
      digests_o  <= 0;
    end else begin
      if (msg_mon.valid && msg_mon.ready) begin
        if (msg_mon.byte_present) begin
          byte_count = byte_count + 1'b1;
          absorb_byte(msg_mon.data_byte);
        end
        if (msg_mon.end_of_message) finish_message();
      end
      if (dig_mon.valid && dig_mon.ready) begin
        if (digest_fifo.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected digest beat: word %h index %0d last %0b",
                     dig_mon.digest_word, dig_mon.word_index, dig_mon.last_word);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = digest_fifo.pop_front();
          if (want.word !== dig_mon.digest_word || want.index !== dig_mon.word_index ||
              want.last !== dig_mon.last_word) begin
            if (mismatches < 10) begin
              $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       want.word, want.index, want.last, dig_mon.digest_word,
                       dig_mon.word_index, dig_mon.last_word);
            end
            mismatches <= mismatches + 1;
          end
          if (want.last) digests_o <= digests_o + 1;
        end
      end
      pending_o = digest_fifo.size();
    end
  end

  assign errors_o  = mismatches;
endmodule

// ----- tb/sha256_stream_hash_test.sv -----
// ---------------------------------------------------------------------------
// sha256_stream_hash_test
// Stimulus and verdict for the stream hash: directed messages, then random
// messages, short or with lengths around block boundaries, under varying idle and
// stall patterns, with a long output hold-off.
// ---------------------------------------------------------------------------
module sha256_stream_hash_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   digests;
  int   mode;
  int   item_count;
  logic hold_req;
  logic stim_done;

  sha_in_if  in_bus ();
  sha_out_if out_bus ();

  sha256_stream_hash DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  sha256_stream_hash_check checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .msg_mon   (in_bus),
    .dig_mon   (out_bus),
    .errors_o  (errors),
    .pending_o (pending),
    .digests_o (digests)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int idle_pct(input int m, input bit sender);
    case (m)
      1:       return sender ? 53 : 0;
      2:       return sender ? 0 : 53;
      3:       return 13;
      default: return 0;
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic present, input logic eom);
    mode = (item_count / 75) % 4;
    while ($urandom_range(99) < idle_pct(mode, 1'b1)) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.data_byte      <= b;
    in_bus.byte_present   <= present;
    in_bus.end_of_message <= eom;
    do @(posedge clk_i); while (!in_bus.ready);
    item_count++;
  endtask

  task automatic send_message(input int len, input bit eom_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, eom_with_byte && (i == len - 1));
    end
    if (!eom_with_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= idle_pct(mode, 1'b0));
    end
  end

  initial begin
    int len;
    int msg_num;
    hold_req              = 1'b0;
    stim_done             = 1'b0;
    mode                  = 0;
    item_count            = 0;
    rst_ni                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = '0;
    in_bus.byte_present   = 1'b0;
    in_bus.end_of_message = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'haa, 1'b1, 1'b1);
    send_message(5, 1'b1);

    msg_num = 0;
    while (item_count < 300) begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(5))
          0:       len = 55;
          1:       len = 56;
          2:       len = 63;
          3:       len = 64;
          4:       len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(20);
      end
      if (msg_num == 2) begin
        fork
          begin
            hold_req <= 1'b1;
            repeat (400) @(posedge clk_i);
            hold_req <= 1'b0;
          end
        join_none
      end
      send_message(len, $urandom_range(1));
      msg_num++;
    end
    in_bus.valid <= 1'b0;
    mode = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Run covered %0d input beats and %0d digests over four idle patterns,",
             item_count, digests);
    $display("including empty messages, block-boundary lengths and a long output hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/sha_pkg.sv
hw/rtl/sha_if.sv
hw/rtl/sha_core.sv
hw/rtl/sha256_stream_hash.sv
tb/sha256_stream_hash_check.sv
tb/sha256_stream_hash_test.sv
